FILE: rtl/ssnd_pkg.sv
// Shared types, codes and the segment map for the seven-segment number display.
// No dependencies; every other file in the project refers to this package.
package ssnd_pkg;

    // Command codes carried in tuser of the input stream.
    localparam logic [1:0] CMD_SHOW_INT = 2'd0;
    localparam logic [1:0] CMD_SET_SYM  = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // Symbol codes with a special meaning.
    localparam logic [4:0] SYM_BLANK = 5'd20;
    localparam logic [4:0] SYM_DOT   = 5'd21;
    localparam logic [4:0] SYM_MINUS = 5'd22;

    // Range of integers that fit on four digits.
    localparam int SHOW_MIN = -999;
    localparam int SHOW_MAX = 9999;

    // Magnitude width of a displayable integer and its conversion step count.
    localparam int MAG_W  = 14;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam int BCD_W  = 16;

    typedef logic [4:0]            t_sym;
    typedef logic [MAG_W-1:0]      t_mag;
    typedef logic [3:0][3:0]       t_digits;

    // Segment pattern of a symbol code, bit 0 segment a up to bit 7 the dot.
    function automatic logic [7:0] seg_lookup(input t_sym code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h6F;
            5'd10:   seg = 8'hBF;
            5'd11:   seg = 8'h86;
            5'd12:   seg = 8'hDB;
            5'd13:   seg = 8'hCF;
            5'd14:   seg = 8'hE6;
            5'd15:   seg = 8'hED;
            5'd16:   seg = 8'hFD;
            5'd17:   seg = 8'h87;
            5'd18:   seg = 8'hFF;
            5'd19:   seg = 8'hEF;
            5'd20:   seg = 8'h00;
            5'd21:   seg = 8'h80;
            5'd22:   seg = 8'h40;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: rtl/ssnd_bcd_conv.sv
// Iterative binary-to-BCD converter (shift and add three), one bit per cycle.
// Depends on ssnd_pkg for widths and the digit type.
module ssnd_bcd_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ssnd_pkg::t_mag      i_mag,
    output logic                o_done,
    output ssnd_pkg::t_digits   o_digits
);

    localparam int SHIFT_W = ssnd_pkg::BCD_W + ssnd_pkg::MAG_W;

    logic                          r_busy;
    logic                          r_done;
    logic [ssnd_pkg::CNT_W-1:0]    r_cnt;
    logic [SHIFT_W-1:0]            r_shift;
    logic [SHIFT_W-1:0]            n_shift;

    // One step: add three to every BCD digit of five or more, then shift left.
    always_comb begin
        logic [SHIFT_W-1:0] adj;
        adj = r_shift;
        for (int k = 0; k < 4; k++) begin
            if (r_shift[ssnd_pkg::MAG_W + 4*k +: 4] >= 4'd5) begin
                adj[ssnd_pkg::MAG_W + 4*k +: 4] = r_shift[ssnd_pkg::MAG_W + 4*k +: 4] + 4'd3;
            end
        end
        n_shift = {adj[SHIFT_W-2:0], 1'b0};
    end

    // Step sequencer: load on start, run MAG_W steps, flag completion for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ssnd_pkg::CNT_W'(ssnd_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift register holds no control state and needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= {{ssnd_pkg::BCD_W{1'b0}}, i_mag};
        end else if (r_busy) begin
            r_shift <= n_shift;
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_shift[SHIFT_W-1 -: ssnd_pkg::BCD_W];

endmodule

FILE: rtl/seven_segment_number_display.sv
// Four-digit multiplexed seven-segment display driver, top level.
// Depends on ssnd_pkg and ssnd_bcd_conv.
//
// The block keeps four symbol codes, blank after reset, and answers every input word
// with exactly one output word: the enabled digit and its segment pattern. A show-integer
// word in the range -999 to 9999 runs through the 14-step shift-and-add-three conversion
// loop before its result is emitted; every other word, including an integer out of range
// (shown as four dots), goes straight to emit. Only one word is in work at a time;
// a finished result waits in the output register while the next word is accepted.
module seven_segment_number_display #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Scan period register write port.
    input  logic        i_scan_period_wr_en,
    input  logic [15:0] i_scan_period_wr_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] number, [20:16] symbol_code,
                                        // [22:21] position, [23] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] segments, [9:8] active_digit,
                                        // [15:10] zero
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                r_state;
    ssnd_pkg::t_sym [3:0]      r_store;
    logic [1:0]                r_scan_digit;
    logic [TIMER_BITS-1:0]     r_tick_count;
    logic [15:0]               r_scan_period;
    logic                      r_neg;
    logic                      r_out_valid;
    logic [7:0]                r_out_seg;
    logic [1:0]                r_out_digit;

    logic                      in_accept;
    logic                      out_free;
    logic [1:0]                in_cmd;
    logic signed [15:0]        in_number;
    ssnd_pkg::t_sym            in_symbol;
    logic [1:0]                in_position;
    logic                      in_range;
    logic [15:0]               abs_number;
    logic                      conv_start;
    logic                      conv_done;
    ssnd_pkg::t_digits         conv_digits;
    logic [TIMER_BITS-1:0]     tick_inc;
    logic                      tick_wrap;
    ssnd_pkg::t_sym [3:0]      num_store;

    // Unpack the input word.
    assign in_cmd      = s_axis_tuser;
    assign in_number   = s_axis_tdata[15:0];
    assign in_symbol   = s_axis_tdata[20:16];
    assign in_position = s_axis_tdata[22:21];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Range check and magnitude of the integer to show.
    assign in_range   = (32'(in_number) >= 32'(ssnd_pkg::SHOW_MIN))
                        && (32'(in_number) <= 32'(ssnd_pkg::SHOW_MAX));
    assign abs_number = in_number[15] ? 16'(-in_number) : in_number;
    assign conv_start = in_accept && (in_cmd == ssnd_pkg::CMD_SHOW_INT) && in_range;

    ssnd_bcd_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (conv_start),
        .i_mag    (abs_number[ssnd_pkg::MAG_W-1:0]),
        .o_done   (conv_done),
        .o_digits (conv_digits)
    );

    // Scan timer: increment first, then compare against the period.
    assign tick_inc  = r_tick_count + 1'b1;
    assign tick_wrap = CMP_W'(tick_inc) > CMP_W'(r_scan_period);

    // Right-aligned digits, minus sign just before the leading digit, blanks elsewhere.
    always_comb begin
        logic [2:0] top;
        logic [2:0] k;
        if (conv_digits[3] != 4'd0) begin
            top = 3'd3;
        end else if (conv_digits[2] != 4'd0) begin
            top = 3'd2;
        end else if (conv_digits[1] != 4'd0) begin
            top = 3'd1;
        end else begin
            top = 3'd0;
        end
        for (int p = 0; p < 4; p++) begin
            k = 3'(3 - p);
            if (k <= top) begin
                num_store[p] = {1'b0, conv_digits[k[1:0]]};
            end else if (r_neg && (k == top + 3'd1)) begin
                num_store[p] = ssnd_pkg::SYM_MINUS;
            end else begin
                num_store[p] = ssnd_pkg::SYM_BLANK;
            end
        end
    end

    // Sequencer, symbol store and scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_store       <= {4{ssnd_pkg::SYM_BLANK}};
            r_scan_digit  <= 2'd0;
            r_tick_count  <= '0;
            r_scan_period <= 16'd2;
        end else begin
            if (i_scan_period_wr_en) begin
                r_scan_period <= i_scan_period_wr_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_EMIT;
                        unique case (in_cmd)
                            ssnd_pkg::CMD_SHOW_INT: begin
                                if (in_range) begin
                                    r_state <= ST_CONV;
                                end else begin
                                    r_store <= {4{ssnd_pkg::SYM_DOT}};
                                end
                            end
                            ssnd_pkg::CMD_SET_SYM: begin
                                r_store[in_position] <= in_symbol;
                            end
                            ssnd_pkg::CMD_TICK: begin
                                if (tick_wrap) begin
                                    r_tick_count <= '0;
                                    r_scan_digit <= r_scan_digit + 2'd1;
                                end else begin
                                    r_tick_count <= tick_inc;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        r_store <= num_store;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Sign of the integer under conversion.
    always_ff @(posedge i_clk) begin
        if (conv_start) begin
            r_neg <= in_number[15];
        end
    end

    // Output register: loaded from the updated store once the previous word has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_out_seg   <= ssnd_pkg::seg_lookup(r_store[r_scan_digit]);
            r_out_digit <= r_scan_digit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_digit, r_out_seg};

endmodule

FILE: sim/ssnd_display_checker.sv
// Checker for the seven-segment number display: predicts every output word from the input
// words and scan period writes it watches, and compares. Depends on ssnd_pkg.
module ssnd_display_checker #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_period_wr_en,
    input  logic [15:0] i_period_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,     // [15:0] number, [20:16] symbol_code,
                                       // [22:21] position, [23] zero
    input  logic [1:0]  i_in_cmd,      // [1:0] cmd
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,    // [7:0] segments, [9:8] active_digit,
                                       // [15:10] zero
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SYM_COUNT = 23;

    // Segment patterns of the defined symbol codes, code 0 in the lowest byte.
    localparam logic [SYM_COUNT-1:0][7:0] SEG_MAP = {
        8'h40, 8'h80, 8'h00,
        8'hEF, 8'hFF, 8'h87, 8'hFD, 8'hED, 8'hE6, 8'hCF, 8'hDB, 8'h86, 8'hBF,
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] digit;
    } t_lit_digit;

    t_lit_digit            lit_digits_due[$];
    t_lit_digit            oldest;
    ssnd_pkg::t_sym        shown_codes [4];
    logic [1:0]            scan_pos;
    logic [TIMER_BITS-1:0] tick_total;
    logic [15:0]           scan_period;

    function automatic logic [7:0] segments_of(input ssnd_pkg::t_sym code);
        return (code < SYM_COUNT) ? SEG_MAP[code] : 8'h00;
    endfunction

    // Writes a signed integer right-aligned, or four dots when it does not fit.
    task automatic show_number(input logic [15:0] raw);
        int          value;
        int unsigned mag;
        int          p;
        value = $signed(raw);
        if (value < ssnd_pkg::SHOW_MIN || value > ssnd_pkg::SHOW_MAX) begin
            for (p = 0; p < 4; p++) shown_codes[p] = ssnd_pkg::SYM_DOT;
        end else begin
            for (p = 0; p < 4; p++) shown_codes[p] = ssnd_pkg::SYM_BLANK;
            mag = (value < 0) ? -value : value;
            p = 3;
            shown_codes[p] = ssnd_pkg::t_sym'(mag % 10);
            mag = mag / 10;
            while (mag > 0) begin
                p--;
                shown_codes[p] = ssnd_pkg::t_sym'(mag % 10);
                mag = mag / 10;
            end
            // A negative value has at most three digits, so the sign always fits.
            if (value < 0) shown_codes[p-1] = ssnd_pkg::SYM_MINUS;
        end
    endtask

    // Applies one accepted input word and queues the digit it should light.
    task automatic predict_lit_digit(input logic [1:0] cmd, input logic [23:0] fields);
        case (cmd)
            ssnd_pkg::CMD_SHOW_INT: show_number(fields[15:0]);
            ssnd_pkg::CMD_SET_SYM:  shown_codes[fields[22:21]] = fields[20:16];
            ssnd_pkg::CMD_TICK: begin
                // The counter is incremented first and compared afterwards.
                tick_total = tick_total + 1'b1;
                if (tick_total > scan_period) begin
                    tick_total = '0;
                    scan_pos   = scan_pos + 2'd1;
                end
            end
            default: ;
        endcase
        lit_digits_due.push_back('{segments: segments_of(shown_codes[scan_pos]),
                                   digit: scan_pos});
    endtask

    // Results are compared before new words are predicted, so a spurious word at the
    // same edge as an input word is never matched against that word's prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 4; p++) shown_codes[p] = ssnd_pkg::SYM_BLANK;
            scan_pos    = '0;
            tick_total  = '0;
            scan_period = 16'd2;
            lit_digits_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (lit_digits_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected word, expected none, got %h", $time, i_out_data);
                end else begin
                    oldest = lit_digits_due.pop_front();
                    if (i_out_data[7:0] !== oldest.segments) begin
                        o_fail_count++;
                        $display("%0t: segments expected %h, got %h", $time,
                                 oldest.segments, i_out_data[7:0]);
                    end
                    if (i_out_data[9:8] !== oldest.digit) begin
                        o_fail_count++;
                        $display("%0t: active digit expected %0d, got %0d", $time,
                                 oldest.digit, i_out_data[9:8]);
                    end
                    if (i_out_data[15:10] !== 6'd0) begin
                        o_fail_count++;
                        $display("%0t: padding expected %h, got %h", $time, 6'd0,
                                 i_out_data[15:10]);
                    end
                end
            end
            if (i_period_wr_en) scan_period = i_period_wr_data;
            if (i_in_valid && i_in_ready) predict_lit_digit(i_in_cmd, i_in_data);
        end
        o_pending = lit_digits_due.size();
    end

endmodule

FILE: sim/tb_seven_segment_number_display.sv
// Testbench top for the seven-segment number display: clock, reset, stimulus and verdict.
// Depends on ssnd_pkg, seven_segment_number_display and ssnd_display_checker.
module tb_seven_segment_number_display;

    localparam int         TIMER_BITS    = 16;
    localparam int         IDLE_PCT      = 28;
    localparam int         PHASE_WORDS   = 250;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         TICK_SWEEP    = 40;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_scan_period_wr_en = 1'b0;
    logic [15:0] i_scan_period_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    int          fail_count;
    int          pending_words;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    seven_segment_number_display #(.TIMER_BITS(TIMER_BITS)) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_scan_period_wr_en   (i_scan_period_wr_en),
        .i_scan_period_wr_data (i_scan_period_wr_data),
        .s_axis_tvalid         (s_axis_tvalid),
        .s_axis_tready         (s_axis_tready),
        .s_axis_tdata          (s_axis_tdata),
        .s_axis_tuser          (s_axis_tuser),
        .m_axis_tvalid         (m_axis_tvalid),
        .m_axis_tready         (m_axis_tready),
        .m_axis_tdata          (m_axis_tdata)
    );

    ssnd_display_checker #(.TIMER_BITS(TIMER_BITS)) display_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_period_wr_en   (i_scan_period_wr_en),
        .i_period_wr_data (i_scan_period_wr_data),
        .i_in_valid       (s_axis_tvalid),
        .i_in_ready       (s_axis_tready),
        .i_in_data        (s_axis_tdata),
        .i_in_cmd         (s_axis_tuser),
        .i_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .i_out_data       (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls at random except during steady stretches.
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [22:0] pack_fields(input logic [1:0] pos,
                                                input ssnd_pkg::t_sym code,
                                                input logic [15:0] num);
        return {pos, code, num};
    endfunction

    // Presents one word after an optional random gap and holds it until accepted.
    task automatic send_word(input logic [1:0] cmd, input logic [22:0] fields);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, fields};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Waits until every result has drained, as the block must be idle for a write.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_words != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_scan_period(input logic [15:0] period);
        drain_results();
        i_scan_period_wr_en   <= 1'b1;
        i_scan_period_wr_data <= period;
        @(posedge i_clk);
        i_scan_period_wr_en   <= 1'b0;
    endtask

    // Mostly ticks, numbers and symbol writes; numbers lean to the displayable range
    // and its edges, with the full 16-bit range now and then.
    task automatic send_random_words(input int count);
        int          roll;
        int          offset;
        logic [22:0] fields;
        logic [15:0] num;
        repeat (count) begin
            roll   = $urandom_range(0, 99);
            fields = 23'($urandom);
            if (roll < 45) begin
                send_word(ssnd_pkg::CMD_TICK, fields);
            end else if (roll < 70) begin
                offset = $urandom_range(0, 3);
                case ($urandom_range(0, 4))
                    0, 1, 2: num = 16'($urandom_range(0, 10998) - 999);
                    3:       num = $urandom_range(0, 1) ? 16'(-1000 + offset)
                                                        : 16'(9998 + offset);
                    default: num = 16'($urandom);
                endcase
                fields[15:0] = num;
                send_word(ssnd_pkg::CMD_SHOW_INT, fields);
            end else if (roll < 95) begin
                send_word(ssnd_pkg::CMD_SET_SYM, fields);
            end else begin
                send_word(CMD_NONE, fields);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset scan period.
        send_word(CMD_NONE, '1);
        send_word(ssnd_pkg::CMD_TICK, '0);
        send_word(ssnd_pkg::CMD_TICK, '0);
        send_word(ssnd_pkg::CMD_TICK, '0);
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd3, 5'd31, 16'd0));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd0, 5'd0, 16'd9999));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd2, 5'd21, -16'sd999));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd1, 5'd10, 16'd10000));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd3, 5'd7, -16'sd1000));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd0, 5'd31, 16'h7FFF));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd3, 5'd0, 16'h8000));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd1, 5'd18, 16'd7));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd2, 5'd5, -16'sd42));
        send_word(ssnd_pkg::CMD_SHOW_INT, pack_fields(2'd0, 5'd12, -16'sd5));
        send_word(ssnd_pkg::CMD_SET_SYM, pack_fields(2'd0, 5'd31, 16'hFFFF));
        send_word(ssnd_pkg::CMD_SET_SYM, pack_fields(2'd1, ssnd_pkg::SYM_MINUS, 16'h5A5A));
        send_word(ssnd_pkg::CMD_SET_SYM, pack_fields(2'd2, 5'd19, 16'h0000));
        send_word(ssnd_pkg::CMD_SET_SYM, pack_fields(2'd3, 5'd0, 16'hA5A5));
        // Writes to the enabled digit show in the very next word.
        send_word(ssnd_pkg::CMD_SET_SYM, pack_fields(2'd1, ssnd_pkg::SYM_DOT, 16'h1234));
        send_word(ssnd_pkg::CMD_SET_SYM, pack_fields(2'd1, 5'd10, 16'hFEDC));
        send_word(ssnd_pkg::CMD_TICK, '1);

        // Random phases over a range of scan periods, the extremes among them.
        send_random_words(PHASE_WORDS);
        set_scan_period(16'd0);
        send_random_words(PHASE_WORDS);
        set_scan_period(16'd1);
        steady = 1'b1;
        send_random_words(PHASE_WORDS);
        steady = 1'b0;
        set_scan_period(16'd3);
        send_random_words(PHASE_WORDS);

        // At the largest period the scan stands still while ticks keep arriving.
        set_scan_period(16'hFFFF);
        send_random_words(PHASE_WORDS / 2);
        steady = 1'b1;
        repeat (TICK_SWEEP) send_word(ssnd_pkg::CMD_TICK, 23'($urandom));
        steady = 1'b0;
        send_random_words(PHASE_WORDS / 2);

        set_scan_period(16'($urandom_range(0, 5)));
        send_random_words(PHASE_WORDS);
        set_scan_period(16'd2);
        send_random_words(PHASE_WORDS);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
